### rtl/kphq_pkg.sv
// Package for the knob position hysteresis quantizer: beat types, constants, boundary tables.
package kphq_pkg;

    localparam int ADC_W      = 10;
    localparam int MIN_W      = 4;
    localparam int SEC_W      = 6;
    localparam int SIDX_W     = 4;
    localparam int MIN_STEPS  = 11;
    localparam int SEC_STEPS  = 12;
    localparam int SEC_STRIDE = 5;
    localparam int PROD_W     = ADC_W + 4;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HYST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEC_HYST = 1'b1;

    localparam logic [ADC_W-1:0] HYST_RESET = 10'd16;

    typedef struct packed {
        logic [ADC_W-1:0] minutes_sample;
        logic [ADC_W-1:0] seconds_sample;
    } in_beat_t;

    typedef struct packed {
        logic [MIN_W-1:0] minutes_value;
        logic [SEC_W-1:0] seconds_value;
    } out_beat_t;

    // lower boundary of minutes setting v: floor(1024*v/11)
    function automatic logic [ADC_W-1:0] min_bound(input logic [MIN_W-1:0] v);
        logic [ADC_W-1:0] b;
        case (v)
            4'd0:    b = 10'd0;
            4'd1:    b = 10'd93;
            4'd2:    b = 10'd186;
            4'd3:    b = 10'd279;
            4'd4:    b = 10'd372;
            4'd5:    b = 10'd465;
            4'd6:    b = 10'd558;
            4'd7:    b = 10'd651;
            4'd8:    b = 10'd744;
            4'd9:    b = 10'd837;
            4'd10:   b = 10'd930;
            default: b = 10'd0;
        endcase
        return b;
    endfunction

    // lower boundary of seconds step i (value 5*i): floor(1024*5*i/60)
    function automatic logic [ADC_W-1:0] sec_bound(input logic [SIDX_W-1:0] i);
        logic [ADC_W-1:0] b;
        case (i)
            4'd0:    b = 10'd0;
            4'd1:    b = 10'd85;
            4'd2:    b = 10'd170;
            4'd3:    b = 10'd256;
            4'd4:    b = 10'd341;
            4'd5:    b = 10'd426;
            4'd6:    b = 10'd512;
            4'd7:    b = 10'd597;
            4'd8:    b = 10'd682;
            4'd9:    b = 10'd768;
            4'd10:   b = 10'd853;
            4'd11:   b = 10'd938;
            default: b = 10'd0;
        endcase
        return b;
    endfunction

endpackage

### rtl/knob_position_hysteresis_quantizer_unit.sv
// Top level of the knob position hysteresis quantizer.
// Each input beat carries one minutes and one seconds ADC sample; each yields one output
// beat with the held minutes (0..10) and seconds (0..55, steps of 5) after hysteresis.
// Two register stages (input, result) with table lookup and compare between them:
// out_valid rises once a beat moves from the input to the result register, and a new beat is
// taken every cycle while the output side keeps up. Hysteresis registers reset to 16 counts.
module knob_position_hysteresis_quantizer_unit
    import kphq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_beat_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_beat_t            out_data
);

    logic [ADC_W-1:0]  min_hyst_reg;
    logic [ADC_W-1:0]  sec_hyst_reg;
    logic              s1_valid_reg;
    in_beat_t          s1_data_reg;
    logic              s2_valid_reg;
    out_beat_t         s2_data_reg;
    logic [MIN_W-1:0]  held_min_reg;
    logic [SIDX_W-1:0] held_sidx_reg;

    logic              s2_take;
    logic              s1_move;
    logic [PROD_W-1:0] min_prod;
    logic [PROD_W-1:0] sec_prod;
    logic [MIN_W-1:0]  min_cand;
    logic [SIDX_W-1:0] sidx_cand;
    logic [ADC_W:0]    min_up_lim;
    logic [ADC_W:0]    min_dn_sum;
    logic [ADC_W:0]    sec_up_lim;
    logic [ADC_W:0]    sec_dn_sum;
    logic              min_take;
    logic              sec_take;
    logic [MIN_W-1:0]  held_min_next;
    logic [SIDX_W-1:0] held_sidx_next;
    logic [SEC_W-1:0]  sec_value_next;

    assign s2_take  = !s2_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && s2_take;
    assign in_ready = !s1_valid_reg || s2_take;

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

    // candidates: sample*steps/1024
    assign min_prod  = PROD_W'(s1_data_reg.minutes_sample) * PROD_W'(MIN_STEPS);
    assign sec_prod  = PROD_W'(s1_data_reg.seconds_sample) * PROD_W'(SEC_STEPS);
    assign min_cand  = min_prod[PROD_W-1:ADC_W];
    assign sidx_cand = sec_prod[PROD_W-1:ADC_W];

    // up: sample >= bound(cand) + hyst ; down: sample + hyst <= bound(held)
    assign min_up_lim = {1'b0, min_bound(min_cand)} + {1'b0, min_hyst_reg};
    assign min_dn_sum = {1'b0, s1_data_reg.minutes_sample} + {1'b0, min_hyst_reg};
    assign sec_up_lim = {1'b0, sec_bound(sidx_cand)} + {1'b0, sec_hyst_reg};
    assign sec_dn_sum = {1'b0, s1_data_reg.seconds_sample} + {1'b0, sec_hyst_reg};

    always_comb
    begin
        if (min_cand > held_min_reg)
        begin
            min_take = {1'b0, s1_data_reg.minutes_sample} >= min_up_lim;
        end
        else
        begin
            min_take = min_dn_sum <= {1'b0, min_bound(held_min_reg)};
        end

        if (sidx_cand > held_sidx_reg)
        begin
            sec_take = {1'b0, s1_data_reg.seconds_sample} >= sec_up_lim;
        end
        else
        begin
            sec_take = sec_dn_sum <= {1'b0, sec_bound(held_sidx_reg)};
        end

        held_min_next  = min_take ? min_cand : held_min_reg;
        held_sidx_next = sec_take ? sidx_cand : held_sidx_reg;
        sec_value_next = SEC_W'({2'b00, held_sidx_next} * SEC_W'(SEC_STRIDE));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_hyst_reg <= HYST_RESET;
            sec_hyst_reg <= HYST_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_HYST: min_hyst_reg <= cfg_data[ADC_W-1:0];
                CFG_SEC_HYST: sec_hyst_reg <= cfg_data[ADC_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            held_min_reg  <= '0;
            held_sidx_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_take)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s1_move)
            begin
                held_min_reg  <= held_min_next;
                held_sidx_reg <= held_sidx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_move)
        begin
            s2_data_reg.minutes_value <= held_min_next;
            s2_data_reg.seconds_value <= sec_value_next;
        end
    end

endmodule

### rtl/kphq_checker.sv
// Port-level assertions for the knob position hysteresis quantizer, bound to the top level.
module kphq_checker
    import kphq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_beat_t out_data
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // input stalls only when the output side is full and stalled
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with room downstream");

    a_min_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.minutes_value <= 4'd10)
        else $error("minutes out of range");

    a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.seconds_value <= 6'd55)
        else $error("seconds out of range");

endmodule

bind knob_position_hysteresis_quantizer_unit kphq_checker u_kphq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
